FILE: rtl/core/pfr_pkg.sv
package pfr_pkg;

  localparam int SCREEN_COLUMNS_DEF = 128;
  localparam int SCREEN_PAGES_DEF   = 8;
  localparam int HEADER_BYTES       = 7;

  // Command header bytes sent ahead of each page
  localparam logic [7:0] HDR_CTRL     = 8'h80;
  localparam logic [7:0] HDR_PAGE     = 8'hB0;
  localparam logic [7:0] HDR_COL_LO   = 8'h00;
  localparam logic [7:0] HDR_COL_HI   = 8'h10;
  localparam logic [7:0] HDR_START_LN = 8'h40;

  typedef enum logic [2:0] {
    OP_SET     = 3'd0,
    OP_READ    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_REFRESH = 3'd3,
    OP_NEXT    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic       active;
    logic       first;
    logic       last;
    logic       frame_last;
    logic       is_hdr;
    logic [7:0] hdr;
  } xfer_stat_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic [3:0] page);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = HDR_CTRL;
      3'd1:    v = HDR_PAGE + 8'(page);
      3'd2:    v = HDR_CTRL;
      3'd3:    v = HDR_COL_LO;
      3'd4:    v = HDR_CTRL;
      3'd5:    v = HDR_COL_HI;
      3'd6:    v = HDR_START_LN;
      default: v = HDR_CTRL;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/page_framebuffer_refresh_top.sv
// Channel  | Handshake          | Payload
// command  | start_i / busy_o   | operation_i, pos_x_i, pos_y_i, color_i
// result   | done_o (strobe)    | pixel_value_o .. dirty_last_column_o
//
// Every item but clear buffer runs through the execute state: the pixel store is read at
// acceptance and written back in the next cycle; done_o rises the cycle after.
// Clear buffer sweeps the store, one column byte a cycle, over all PAGES*COLUMNS bytes
// (1024 by default), then gives one result.
// After reset the same sweep runs with busy_o high and no result.
// done_o lasts one cycle; the receiver cannot stall, and the next item may be
// accepted while a result is on the ports.
module page_framebuffer_refresh_top #(
  parameter int SCREEN_COLUMNS = pfr_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_PAGES   = pfr_pkg::SCREEN_PAGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] pos_x_i,
  input  logic [6:0] pos_y_i,
  input  logic       color_i,
  output logic       done_o,
  output logic       pixel_value_o,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       page_first_o,
  output logic       page_last_o,
  output logic       frame_last_o,
  output logic       busy_res_o,
  output logic [2:0] dirty_first_page_o,
  output logic [2:0] dirty_last_page_o,
  output logic [6:0] dirty_first_column_o,
  output logic [6:0] dirty_last_column_o
);
  import pfr_pkg::*;

  localparam int DEPTH = SCREEN_PAGES * SCREEN_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int CW    = $clog2(SCREEN_COLUMNS);

  state_e state_q, state_d;

  logic          accept;
  op_e           op_q;
  logic [7:0]    x_q;
  logic [6:0]    y_q;
  logic          color_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  logic          in_range;
  logic [2:0]    bit_sel;
  logic [3:0]    pg;
  logic [7:0]    modified;

  logic [PW-1:0] box_fp_q, box_fp_d, box_lp_q, box_lp_d;
  logic [CW-1:0] box_fc_q, box_fc_d, box_lc_q, box_lc_d;

  logic          xfer_restart, xfer_advance;
  xfer_stat_t    xfer_stat;
  logic [AW-1:0] xfer_addr;

  logic       done_q, done_d;
  logic       pix_q, pix_d;
  logic [7:0] obyte_q, obyte_d;
  logic       valid_q, valid_d;
  logic       pfirst_q, pfirst_d;
  logic       plast_q, plast_d;
  logic       flast_q, flast_d;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  assign pix_addr = AW'(32'(pos_y_i[6:3]) * SCREEN_COLUMNS + 32'(pos_x_i));
  assign rd_addr  = (op_e'(operation_i) == OP_NEXT) ? xfer_addr : pix_addr;

  pfr_xfer #(
    .COLUMNS (SCREEN_COLUMNS),
    .PAGES   (SCREEN_PAGES)
  ) u_xfer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (xfer_restart),
    .advance_i (xfer_advance),
    .stat_o    (xfer_stat),
    .addr_o    (xfer_addr)
  );

  // Pixel store: one write and one registered read per cycle, the read only on acceptance
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(operation_i);
      x_q     <= pos_x_i;
      y_q     <= pos_y_i;
      color_q <= color_i;
      addr_q  <= pix_addr;
    end
  end

  always_comb begin
    in_range = (9'(x_q) < 9'(SCREEN_COLUMNS)) && (8'(y_q) < 8'(SCREEN_PAGES * 8));
    bit_sel  = y_q[2:0];
    pg       = y_q[6:3];
    modified = rd_data_q;
    modified[bit_sel] = color_q;
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    mem_we       = 1'b0;
    mem_wa       = addr_q;
    mem_wd       = modified;
    box_fp_d     = box_fp_q;
    box_lp_d     = box_lp_q;
    box_fc_d     = box_fc_q;
    box_lc_d     = box_lc_q;
    xfer_restart = 1'b0;
    xfer_advance = 1'b0;
    done_d       = 1'b0;
    pix_d        = 1'b0;
    obyte_d      = '0;
    valid_d      = 1'b0;
    pfirst_d     = 1'b0;
    plast_d      = 1'b0;
    flast_d      = 1'b0;

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_cnt_q;
        mem_wd    = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          clr_cnt_d = '0;
          state_d   = ST_IDLE;
          done_d    = (state_q == ST_CLEAR);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = (op_e'(operation_i) == OP_CLEAR) ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        case (op_q)
          OP_SET: begin
            if (in_range) begin
              mem_we = 1'b1;
              if (PW'(pg) < box_fp_q) box_fp_d = PW'(pg);
              if (PW'(pg) > box_lp_q) box_lp_d = PW'(pg);
              if (CW'(x_q) < box_fc_q) box_fc_d = CW'(x_q);
              if (CW'(x_q) > box_lc_q) box_lc_d = CW'(x_q);
            end
          end
          OP_READ: begin
            pix_d = in_range && rd_data_q[bit_sel];
          end
          OP_REFRESH: begin
            if (!xfer_stat.active) begin
              xfer_restart = 1'b1;
              box_fp_d     = PW'(SCREEN_PAGES - 1);
              box_lp_d     = '0;
              box_fc_d     = CW'(SCREEN_COLUMNS - 1);
              box_lc_d     = '0;
            end
          end
          OP_NEXT: begin
            if (xfer_stat.active) begin
              xfer_advance = 1'b1;
              obyte_d      = xfer_stat.is_hdr ? xfer_stat.hdr : rd_data_q;
              valid_d      = 1'b1;
              pfirst_d     = xfer_stat.first;
              plast_d      = xfer_stat.last;
              flast_d      = xfer_stat.frame_last;
            end
          end
          default: begin
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
      box_fp_q  <= PW'(SCREEN_PAGES - 1);
      box_lp_q  <= '0;
      box_fc_q  <= CW'(SCREEN_COLUMNS - 1);
      box_lc_q  <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
      box_fp_q  <= box_fp_d;
      box_lp_q  <= box_lp_d;
      box_fc_q  <= box_fc_d;
      box_lc_q  <= box_lc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    obyte_q  <= obyte_d;
    valid_q  <= valid_d;
    pfirst_q <= pfirst_d;
    plast_q  <= plast_d;
    flast_q  <= flast_d;
  end

  assign done_o               = done_q;
  assign pixel_value_o        = pix_q;
  assign out_byte_o           = obyte_q;
  assign byte_valid_o         = valid_q;
  assign page_first_o         = pfirst_q;
  assign page_last_o          = plast_q;
  assign frame_last_o         = flast_q;
  assign busy_res_o           = xfer_stat.active;
  assign dirty_first_page_o   = 3'(box_fp_q);
  assign dirty_last_page_o    = 3'(box_lp_q);
  assign dirty_first_column_o = 7'(box_fc_q);
  assign dirty_last_column_o  = 7'(box_lc_q);

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_EXEC) || $past(state_q == ST_CLEAR))
    else $error("result strobe without a finished item");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != ST_IDLE)
    else $error("pixel store written while idle");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && flast_q |-> plast_q && !xfer_stat.active)
    else $error("frame end without page end or with transfer still running");

  a_stream_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && valid_q && !flast_q |-> xfer_stat.active)
    else $error("transfer stopped before the final byte");

endmodule

FILE: rtl/core/pfr_xfer.sv
module pfr_xfer #(
  parameter int COLUMNS = pfr_pkg::SCREEN_COLUMNS_DEF,
  parameter int PAGES   = pfr_pkg::SCREEN_PAGES_DEF,
  localparam int AW     = $clog2(PAGES * COLUMNS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic                 advance_i,
  output pfr_pkg::xfer_stat_t  stat_o,
  output logic [AW-1:0]        addr_o
);
  import pfr_pkg::*;

  localparam int PAGE_LEN = HEADER_BYTES + COLUMNS;
  localparam int BW       = $clog2(PAGE_LEN);
  localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;

  logic          active_q, active_d;
  logic [PW-1:0] page_q, page_d;
  logic [BW-1:0] byte_q, byte_d;
  logic [BW-1:0] col;

  always_comb begin
    stat_o.active     = active_q;
    stat_o.first      = (byte_q == '0);
    stat_o.last       = (byte_q == BW'(PAGE_LEN - 1));
    stat_o.frame_last = stat_o.last && (page_q == PW'(PAGES - 1));
    stat_o.is_hdr     = (byte_q < BW'(HEADER_BYTES));
    stat_o.hdr        = hdr_byte(byte_q[2:0], 4'(page_q));
    // Wraps during the header, where the data byte is not used
    col    = byte_q - BW'(HEADER_BYTES);
    addr_o = AW'(32'(page_q) * COLUMNS + 32'(col));
  end

  always_comb begin
    active_d = active_q;
    page_d   = page_q;
    byte_d   = byte_q;
    if (restart_i) begin
      active_d = 1'b1;
      page_d   = '0;
      byte_d   = '0;
    end else if (advance_i) begin
      if (stat_o.last) begin
        byte_d = '0;
        if (stat_o.frame_last) begin
          active_d = 1'b0;
          page_d   = '0;
        end else begin
          page_d = page_q + 1'b1;
        end
      end else begin
        byte_d = byte_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      page_q   <= '0;
      byte_q   <= '0;
    end else begin
      active_q <= active_d;
      page_q   <= page_d;
      byte_q   <= byte_d;
    end
  end

endmodule

FILE: dv/page_framebuffer_refresh_top_tb.sv
module page_framebuffer_refresh_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfr_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int COLS           = SCREEN_COLUMNS_DEF;
  localparam int PAGES          = SCREEN_PAGES_DEF;
  localparam int PAGE_BYTES     = HEADER_BYTES + COLS;
  localparam int FRAME_BYTES    = PAGES * PAGE_BYTES;
  localparam int DRAIN_CYCLES   = 32;
  localparam int TIMEOUT_CYCLES = 4_000_000;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] x;
    logic [6:0] y;
    logic       color;
  } fb_cmd_t;

  typedef struct packed {
    logic       pixel_value;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       page_first;
    logic       page_last;
    logic       frame_last;
    logic       busy_res;
    logic [2:0] dirty_first_page;
    logic [2:0] dirty_last_page;
    logic [6:0] dirty_first_column;
    logic [6:0] dirty_last_column;
  } fb_res_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start_i     = 1'b0;
  logic [2:0] operation_i = '0;
  logic [7:0] pos_x_i     = '0;
  logic [6:0] pos_y_i     = '0;
  logic       color_i     = 1'b0;
  logic       busy_o;
  logic       done_o;
  logic       pixel_value_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       page_first_o;
  logic       page_last_o;
  logic       frame_last_o;
  logic       busy_res_o;
  logic [2:0] dirty_first_page_o;
  logic [2:0] dirty_last_page_o;
  logic [6:0] dirty_first_column_o;
  logic [6:0] dirty_last_column_o;

  page_framebuffer_refresh_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .operation_i         (operation_i),
    .pos_x_i             (pos_x_i),
    .pos_y_i             (pos_y_i),
    .color_i             (color_i),
    .done_o              (done_o),
    .pixel_value_o       (pixel_value_o),
    .out_byte_o          (out_byte_o),
    .byte_valid_o        (byte_valid_o),
    .page_first_o        (page_first_o),
    .page_last_o         (page_last_o),
    .frame_last_o        (frame_last_o),
    .busy_res_o          (busy_res_o),
    .dirty_first_page_o  (dirty_first_page_o),
    .dirty_last_page_o   (dirty_last_page_o),
    .dirty_first_column_o(dirty_first_column_o),
    .dirty_last_column_o (dirty_last_column_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  fb_cmd_t cmd_q[$];
  fb_res_t expected_res_q[$];
  fb_cmd_t cmd_live;
  fb_res_t res_pred;
  int      sender_idle_pct = 27;
  int      err_cnt         = 0;
  int      items_accepted  = 0;
  int      results_seen    = 0;
  int      frames_seen     = 0;
  int      lit_reads       = 0;
  int      stream_bytes    = 0;

  // Shadow framebuffer and refresh state
  logic [7:0] shadow_fb [PAGES][COLS];
  logic       xfer_on   = 1'b0;
  int         xfer_page = 0;
  int         xfer_byte = 0;
  int         box_pg_lo = PAGES - 1;
  int         box_pg_hi = 0;
  int         box_col_lo = COLS - 1;
  int         box_col_hi = 0;

  // Generation-side view of the transfer, to shape the stream
  bit gen_busy       = 1'b0;
  int gen_bytes_left = 0;
  bit gen_frame_done = 1'b0;

  initial begin
    foreach (shadow_fb[p, c]) shadow_fb[p][c] = '0;
  end

  task automatic framebuffer_step(input fb_cmd_t c, output fb_res_t r);
    bit   in_range;
    int   page;
    int   bit_n;
    int   col_x;
    logic [7:0] v;
    r        = '0;
    in_range = (c.x < COLS) && (c.y < PAGES * 8);
    page     = int'(c.y[6:3]);
    bit_n    = int'(c.y[2:0]);
    col_x    = int'(c.x);
    case (c.op)
      OP_SET: begin
        if (in_range) begin
          if (page < box_pg_lo) box_pg_lo = page;
          if (page > box_pg_hi) box_pg_hi = page;
          if (col_x < box_col_lo) box_col_lo = col_x;
          if (col_x > box_col_hi) box_col_hi = col_x;
          shadow_fb[page][col_x][bit_n] = c.color;
        end
      end
      OP_READ: begin
        if (in_range) r.pixel_value = shadow_fb[page][col_x][bit_n];
      end
      OP_CLEAR: begin
        foreach (shadow_fb[p, col]) shadow_fb[p][col] = '0;
      end
      OP_REFRESH: begin
        if (!xfer_on) begin
          box_pg_lo  = PAGES - 1;
          box_pg_hi  = 0;
          box_col_lo = COLS - 1;
          box_col_hi = 0;
          xfer_on    = 1'b1;
          xfer_page  = 0;
          xfer_byte  = 0;
        end
      end
      OP_NEXT: begin
        if (xfer_on) begin
          case (xfer_byte)
            0, 2, 4: v = HDR_CTRL;
            1:       v = HDR_PAGE + 8'(xfer_page);
            3:       v = HDR_COL_LO;
            5:       v = HDR_COL_HI;
            6:       v = HDR_START_LN;
            default: v = shadow_fb[xfer_page][xfer_byte - HEADER_BYTES];
          endcase
          r.out_byte   = v;
          r.byte_valid = 1'b1;
          r.page_first = (xfer_byte == 0);
          r.page_last  = (xfer_byte == PAGE_BYTES - 1);
          r.frame_last = r.page_last && (xfer_page == PAGES - 1);
          if (r.page_last) begin
            xfer_byte = 0;
            if (r.frame_last) begin
              xfer_on   = 1'b0;
              xfer_page = 0;
            end else begin
              xfer_page++;
            end
          end else begin
            xfer_byte++;
          end
        end
      end
      default: ;
    endcase
    r.busy_res           = xfer_on;
    r.dirty_first_page   = 3'(box_pg_lo);
    r.dirty_last_page    = 3'(box_pg_hi);
    r.dirty_first_column = 7'(box_col_lo);
    r.dirty_last_column  = 7'(box_col_hi);
  endtask

  task automatic push_cmd(input logic [2:0] op, input int x, input int y, input bit color);
    fb_cmd_t c;
    c.op    = op;
    c.x     = 8'(x);
    c.y     = 7'(y);
    c.color = color;
    cmd_q.push_back(c);
    if (op == OP_REFRESH && !gen_busy) begin
      gen_busy       = 1'b1;
      gen_bytes_left = FRAME_BYTES;
    end else if (op == OP_NEXT && gen_busy) begin
      gen_bytes_left--;
      if (gen_bytes_left == 0) begin
        gen_busy       = 1'b0;
        gen_frame_done = 1'b1;
      end
    end
  endtask

  // Half the time a hot window at the screen corners so reads find set pixels
  task automatic random_cmd();
    int roll;
    int sel;
    int x;
    int y;
    logic [2:0] op;
    roll = $urandom_range(999);
    if (gen_busy) begin
      if (roll < 5)        op = OP_CLEAR;
      else if (roll < 20)  op = 3'(OP_NEXT) + 3'($urandom_range(1, 3));
      else if (roll < 60)  op = OP_REFRESH;
      else if (roll < 140) op = OP_READ;
      else if (roll < 240) op = OP_SET;
      else                 op = OP_NEXT;
    end else begin
      if (roll < 5)        op = OP_CLEAR;
      else if (roll < 40)  op = 3'(OP_NEXT) + 3'($urandom_range(1, 3));
      else if (roll < 140) op = OP_REFRESH;
      else if (roll < 200) op = OP_NEXT;
      else if (roll < 520) op = OP_READ;
      else                 op = OP_SET;
    end
    sel = $urandom_range(9);
    if (sel == 0) begin
      x = $urandom_range(255);
      y = $urandom_range(127);
    end else if (sel < 6) begin
      x = $urandom_range(7) + ($urandom_range(1) ? COLS - 8 : 0);
      y = $urandom_range(7) + ($urandom_range(1) ? PAGES * 8 - 8 : 0);
    end else begin
      x = $urandom_range(COLS - 1);
      y = $urandom_range(PAGES * 8 - 1);
    end
    push_cmd(op, x, y, $urandom_range(1));
  endtask

  task automatic fill_random(input int min_items, input bit want_frame);
    int n;
    n              = 0;
    gen_frame_done = 1'b0;
    while (n < min_items || (want_frame && !gen_frame_done)) begin
      random_cmd();
      n++;
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || start_i || expected_res_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Driver: predict on acceptance, then offer the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i     <= 1'b0;
      operation_i <= '0;
      pos_x_i     <= '0;
      pos_y_i     <= '0;
      color_i     <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        framebuffer_step(cmd_live, res_pred);
        expected_res_q.push_back(res_pred);
        items_accepted++;
      end
      if (!start_i || !busy_o) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          cmd_live    = cmd_q.pop_front();
          start_i     <= 1'b1;
          operation_i <= cmd_live.op;
          pos_x_i     <= cmd_live.x;
          pos_y_i     <= cmd_live.y;
          color_i     <= cmd_live.color;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    fb_res_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (frame_last_o === 1'b1) frames_seen++;
      if (byte_valid_o === 1'b1) stream_bytes++;
      if (expected_res_q.size() == 0) begin
        $error("result strobe with no item outstanding");
        err_cnt++;
      end else begin
        want = expected_res_q.pop_front();
        if (want.pixel_value) lit_reads++;
        check_field("pixel_value", 8'(want.pixel_value), 8'(pixel_value_o));
        check_field("out_byte", want.out_byte, out_byte_o);
        check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid_o));
        check_field("page_first", 8'(want.page_first), 8'(page_first_o));
        check_field("page_last", 8'(want.page_last), 8'(page_last_o));
        check_field("frame_last", 8'(want.frame_last), 8'(frame_last_o));
        check_field("busy_res", 8'(want.busy_res), 8'(busy_res_o));
        check_field("dirty_first_page", 8'(want.dirty_first_page),
                    8'(dirty_first_page_o));
        check_field("dirty_last_page", 8'(want.dirty_last_page),
                    8'(dirty_last_page_o));
        check_field("dirty_first_column", 8'(want.dirty_first_column),
                    8'(dirty_first_column_o));
        check_field("dirty_last_column", 8'(want.dirty_last_column),
                    8'(dirty_last_column_o));
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    // Corners, out-of-range pixels, idle next byte, no-op codes,
    // refresh while busy and a clear under a running transfer
    push_cmd(OP_READ, 0, 0, 1'b0);
    push_cmd(OP_NEXT, 0, 0, 1'b0);
    push_cmd(OP_SET, 0, 0, 1'b1);
    push_cmd(OP_SET, COLS - 1, PAGES * 8 - 1, 1'b1);
    push_cmd(OP_READ, COLS - 1, PAGES * 8 - 1, 1'b0);
    push_cmd(OP_SET, COLS, 0, 1'b1);
    push_cmd(OP_SET, 5, PAGES * 8, 1'b1);
    push_cmd(OP_READ, 255, 127, 1'b1);
    push_cmd(OP_SET, COLS - 1, PAGES * 8 - 1, 1'b0);
    push_cmd(OP_READ, COLS - 1, PAGES * 8 - 1, 1'b0);
    push_cmd(3'(OP_NEXT) + 3'd1, 0, 0, 1'b0);
    push_cmd(3'(OP_NEXT) + 3'd2, 255, 127, 1'b1);
    push_cmd(3'(OP_NEXT) + 3'd3, 0, 0, 1'b0);
    push_cmd(OP_REFRESH, 0, 0, 1'b0);
    push_cmd(OP_REFRESH, 0, 0, 1'b0);
    repeat (HEADER_BYTES) push_cmd(OP_NEXT, 0, 0, 1'b0);
    push_cmd(OP_CLEAR, 0, 0, 1'b0);
    push_cmd(OP_NEXT, 0, 0, 1'b0);
    push_cmd(OP_READ, 0, 0, 1'b0);

    fill_random(244, 1'b0);
    wait_drained();
    sender_idle_pct = 84;
    fill_random(244, 1'b0);
    wait_drained();
    sender_idle_pct = 0;
    fill_random(244, 1'b0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("coverage: %0d items, %0d results, %0d stream bytes, %0d frames ended",
             items_accepted, results_seen, stream_bytes, frames_seen);
    $display("          %0d pixel reads found a set pixel", lit_reads);
    if (err_cnt == 0) begin
      $display("page_framebuffer_refresh_top_tb: done, clean");
    end else begin
      $display("page_framebuffer_refresh_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout: %0d results outstanding", expected_res_q.size());
    $display("page_framebuffer_refresh_top_tb: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pfr_pkg.sv
rtl/core/pfr_xfer.sv
rtl/core/page_framebuffer_refresh_top.sv
dv/page_framebuffer_refresh_top_tb.sv
